FILE: sv/ice_pkg.sv
// Shared constants for the indexed circular list engine: request codes
// and result status codes. No dependencies.
`default_nettype none
package ice_pkg;

  localparam int REQ_W = 4;
  localparam int STAT_W = 3;

  localparam logic [REQ_W-1:0] REQ_INS_FIRST = 4'd0;
  localparam logic [REQ_W-1:0] REQ_INS_LAST  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_INS_AT    = 4'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_FIRST = 4'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_LAST  = 4'd4;
  localparam logic [REQ_W-1:0] REQ_DEL_AT    = 4'd5;
  localparam logic [REQ_W-1:0] REQ_DEL_VALUE = 4'd6;
  localparam logic [REQ_W-1:0] REQ_FIND      = 4'd7;
  localparam logic [REQ_W-1:0] REQ_READ      = 4'd8;
  localparam logic [REQ_W-1:0] REQ_SIZE      = 4'd9;
  localparam logic [REQ_W-1:0] REQ_REVERSE   = 4'd10;
  localparam logic [REQ_W-1:0] REQ_CLEAR     = 4'd11;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

endpackage
`default_nettype wire

FILE: sv/ice_cell.sv
// One storage cell of the list ring: holds a word and takes its
// neighbor's word while the ring rotates. Depends on nothing.
`default_nettype none
module ice_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  shift_en,
  input  wire logic [DATA_WIDTH-1:0] d,
  output logic      [DATA_WIDTH-1:0] q
);

  logic [DATA_WIDTH-1:0] word_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      word_r <= d;
    end
  end

  assign q = word_r;

endmodule
`default_nettype wire

FILE: sv/indexed_circular_list_engine_unit.sv
// Indexed list engine top level: ring of ice_cell plus the pass sequencer.
// Depends on ice_pkg and ice_cell.
// Size, reverse, clear, unused codes and early errors answer in the cycle
// after the transfer; insert, delete, read and find turn the ring once and
// answer as the turn ends; delete by value turns it twice if the value is found.
// Throughput: 1 transfer/cycle for immediate requests; a pass request holds
// busy until its pass ends; results are strobed and cannot stall.
// Reset: count 0, forward orientation; cell contents are not cleared.
`default_nettype none
module indexed_circular_list_engine_unit
  import ice_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [REQ_W-1:0]              in_req_type,
  input  wire logic [$clog2(CAPACITY+1)-1:0] in_index,
  input  wire logic [DATA_WIDTH-1:0]         in_value,
  output logic                               out_valid,
  output logic [STAT_W-1:0]                  out_status,
  output logic [DATA_WIDTH-1:0]              out_data,
  output logic [$clog2(CAPACITY)-1:0]        out_position,
  output logic [$clog2(CAPACITY+1)-1:0]      out_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C     = CW'(1);

  typedef enum logic {S_IDLE, S_PASS} state_t;
  // ROT: plain rotation (read, scan); INS: open a gap; DEL: close a gap
  typedef enum logic [1:0] {P_ROT, P_INS, P_DEL} pass_t;

  state_t                state_r;
  pass_t                 pass_r;
  logic [REQ_W-1:0]      req_r;
  logic [IW-1:0]         step_r;
  logic [CW-1:0]         tgt_r;     // physical position of the gap or read
  logic [DATA_WIDTH-1:0] val_r;
  logic [DATA_WIDTH-1:0] carry_r;   // word displaced by an insert
  logic [DATA_WIDTH-1:0] data_r;
  logic [CW-1:0]         count_r;
  logic                  rev_r;     // list is stored back to front
  logic                  found_r;
  logic [IW-1:0]         mpos_r;    // physical position of the match
  logic [IW-1:0]         pos_r;     // logical position for delete by value
  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  logic [IW-1:0]         out_pos_r;

  // ------------------------------------------------------------------
  // Ring of cells. Cell 0 is the head; each rotation every cell takes
  // the word of its right neighbor and the last cell takes tail_d.
  // A full turn of the ring brings every word back to its own cell.
  // ------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_d [CAPACITY];
  logic [DATA_WIDTH-1:0] head;
  logic [DATA_WIDTH-1:0] next_word;
  logic [DATA_WIDTH-1:0] tail_d;
  logic                  shift_en;

  assign shift_en = (state_r == S_PASS);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_tail
      assign cell_d[i] = tail_d;
    end else begin : g_link
      assign cell_d[i] = cell_q[i+1];
    end
    ice_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d        (cell_d[i]),
      .q        (cell_q[i])
    );
  end

  assign head      = cell_q[0];
  assign next_word = cell_q[1];

  // ------------------------------------------------------------------
  // Per-step decisions during a pass
  // ------------------------------------------------------------------
  logic [CW-1:0]         step_ext;
  logic                  before_tgt;
  logic                  at_tgt;
  logic                  last_step;
  logic                  hit;
  logic                  found_nxt;
  logic [IW-1:0]         mpos_nxt;
  logic [IW-1:0]         lpos_nxt;
  logic [DATA_WIDTH-1:0] data_nxt;

  assign step_ext   = CW'(step_r);
  assign before_tgt = (step_ext < tgt_r);
  assign at_tgt     = (step_ext == tgt_r);
  assign last_step  = (step_r == LAST_STEP);

  always_comb begin
    case (pass_r)
      P_INS:   tail_d = before_tgt ? head : (at_tgt ? val_r : carry_r);
      P_DEL:   tail_d = before_tgt ? head : next_word;
      default: tail_d = head;
    endcase
  end

  // first match in storage order, last match when stored reversed
  assign hit       = (step_ext < count_r) && (head == val_r) && (!found_r || rev_r);
  assign found_nxt = found_r | hit;
  assign mpos_nxt  = hit ? step_r : mpos_r;
  assign lpos_nxt  = rev_r ? IW'(count_r - ONE_C - CW'(mpos_nxt)) : mpos_nxt;
  assign data_nxt  = (at_tgt && (pass_r == P_DEL || req_r == REQ_READ)) ? head : data_r;

  // ------------------------------------------------------------------
  // Request decode at the transfer
  // ------------------------------------------------------------------
  logic          accept;
  logic          dec_imm;
  logic [STAT_W-1:0] dec_status;
  pass_t         dec_pass;
  logic [CW-1:0] dec_tgt;
  logic [CW-1:0] lpos;
  logic          is_empty;
  logic          is_full;

  assign accept   = start && (state_r == S_IDLE);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r >= CAP_C);

  always_comb begin
    dec_imm    = 1'b1;
    dec_status = ST_OK;
    dec_pass   = P_ROT;
    dec_tgt    = '0;
    lpos       = '0;
    unique case (in_req_type) inside
      REQ_INS_FIRST, REQ_INS_LAST, REQ_INS_AT: begin
        if (in_req_type == REQ_INS_FIRST) lpos = '0;
        else if (in_req_type == REQ_INS_LAST) lpos = count_r;
        else lpos = in_index;
        if (lpos > count_r) begin
          dec_status = ST_RANGE;
        end else if (is_full) begin
          dec_status = ST_FULL;
        end else begin
          dec_imm  = 1'b0;
          dec_pass = P_INS;
          dec_tgt  = rev_r ? (count_r - lpos) : lpos;
        end
      end
      REQ_DEL_FIRST, REQ_DEL_LAST: begin
        lpos = (in_req_type == REQ_DEL_FIRST) ? '0 : (count_r - ONE_C);
        if (is_empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_imm  = 1'b0;
          dec_pass = P_DEL;
          dec_tgt  = rev_r ? (count_r - ONE_C - lpos) : lpos;
        end
      end
      REQ_DEL_AT: begin
        lpos = in_index;
        if (lpos >= count_r) begin
          dec_status = ST_RANGE;
        end else begin
          dec_imm  = 1'b0;
          dec_pass = P_DEL;
          dec_tgt  = rev_r ? (count_r - ONE_C - lpos) : lpos;
        end
      end
      REQ_DEL_VALUE, REQ_FIND: begin
        if (is_empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_imm = 1'b0;
        end
      end
      REQ_READ: begin
        lpos = in_index;
        if (is_empty) begin
          dec_status = ST_EMPTY;
        end else if (lpos >= count_r) begin
          dec_status = ST_RANGE;
        end else begin
          dec_imm = 1'b0;
          dec_tgt = rev_r ? (count_r - ONE_C - lpos) : lpos;
        end
      end
      default: begin
        dec_imm = 1'b1;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer: state, pass bookkeeping and registered results
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      rev_r       <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r   <= in_req_type;
            val_r   <= in_value;
            pass_r  <= dec_pass;
            tgt_r   <= dec_tgt;
            step_r  <= '0;
            found_r <= 1'b0;
            mpos_r  <= '0;
            data_r  <= '0;
            if (dec_imm) begin
              out_valid_r  <= 1'b1;
              out_status_r <= dec_status;
              out_data_r   <= '0;
              out_pos_r    <= '0;
              if (dec_status == ST_OK && in_req_type == REQ_REVERSE) rev_r <= !rev_r;
              if (dec_status == ST_OK && in_req_type == REQ_CLEAR) count_r <= '0;
            end else begin
              state_r <= S_PASS;
            end
          end
        end
        S_PASS: begin
          carry_r <= head;
          found_r <= found_nxt;
          mpos_r  <= mpos_nxt;
          data_r  <= data_nxt;
          step_r  <= last_step ? '0 : (step_r + 1'b1);
          if (last_step) begin
            out_status_r <= ST_OK;
            out_data_r   <= '0;
            out_pos_r    <= '0;
            if (pass_r == P_INS) begin
              count_r     <= count_r + ONE_C;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else if (pass_r == P_DEL) begin
              count_r     <= count_r - ONE_C;
              out_data_r  <= data_nxt;
              out_pos_r   <= (req_r == REQ_DEL_VALUE) ? pos_r : '0;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else if (req_r == REQ_READ) begin
              out_data_r  <= data_nxt;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else if (!found_nxt) begin
              out_status_r <= ST_NOTFOUND;
              out_valid_r  <= 1'b1;
              state_r      <= S_IDLE;
            end else if (req_r == REQ_FIND) begin
              out_pos_r   <= lpos_nxt;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              // delete by value: second rotation closes the gap at the match
              pos_r  <= lpos_nxt;
              pass_r <= P_DEL;
              tgt_r  <= CW'(mpos_nxt);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data     = out_data_r;
  assign out_position = out_pos_r;
  assign out_count    = count_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("element count beyond capacity");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobed while a pass is running");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid_r || busy))
    else $error("transfer neither answered nor started a pass");

  a_count_steady_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !last_step) |=> $stable(count_r))
    else $error("count changed in the middle of a pass");

endmodule
`default_nettype wire
